FILE: src/wrms_pkg.sv
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared widths, register indexes, status codes and the command and status
// structs that join the controller to the datapath of the RMS current meter.
// ----------------------------------------------------------------------------
package wrms_pkg;

  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned SAMPLE_BITS = 12;

  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned SENS_W     = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CUT_W      = 16;
  localparam int unsigned CENTI_W    = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((CENTI_W + 7) / 8) * 8;

  localparam int unsigned DIFF_W = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
  localparam int unsigned MAG_W  = DIFF_W - 1;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = SQ_W + $clog2(MAX_WINDOW);
  localparam int unsigned CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam int unsigned ROOT_W  = (SUM_W + 1) / 2;
  localparam int unsigned RAD_W   = 2 * ROOT_W;
  localparam int unsigned SCALE_W = 7;
  localparam int unsigned PROD_W  = ROOT_W + SCALE_W;
  localparam int unsigned DVD_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int unsigned DVS_W   = (LEN_W > SENS_W) ? LEN_W : SENS_W;
  localparam int unsigned ITER_W  = $clog2((DVD_W > ROOT_W) ? DVD_W : ROOT_W);

  localparam logic [SCALE_W-1:0] CENTI_PER_UNIT = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CUTOFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUTOFF = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    RANGE_OK   = 2'd0,
    RANGE_LOW  = 2'd1,
    RANGE_HIGH = 2'd2
  } range_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] zero_offset;
    logic [LEN_W-1:0]    len_eff;
    logic [SENS_W-1:0]   sens_eff;
    logic [CUT_W-1:0]    low_cut;
    logic [CUT_W-1:0]    high_cut;
  } cfg_t;

  typedef struct packed {
    logic take_sample;
    logic square;
    logic accumulate;
    logic mean_load;
    logic div_step;
    logic root_load;
    logic root_step;
    logic scale;
    logic conv_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic win_end;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: src/wrms_cfg.sv
// ----------------------------------------------------------------------------
// wrms_cfg
// Configuration register file with write channel; presents the registers
// with window length and sensitivity clamped to their usable ranges.
// ----------------------------------------------------------------------------
module wrms_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wrms_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wrms_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output wrms_pkg::cfg_t                       cfg_o
);

  logic [wrms_pkg::OFFSET_W-1:0] offset_q;
  logic [wrms_pkg::SENS_W-1:0]   sens_q;
  logic [wrms_pkg::LEN_W-1:0]    len_q;
  logic [wrms_pkg::CUT_W-1:0]    low_q;
  logic [wrms_pkg::CUT_W-1:0]    high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= wrms_pkg::OFFSET_W'(2500);
      sens_q   <= wrms_pkg::SENS_W'(100);
      len_q    <= wrms_pkg::LEN_W'(200);
      low_q    <= wrms_pkg::CUT_W'(1);
      high_q   <= wrms_pkg::CUT_W'(2000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wrms_pkg::REG_ZERO_OFFSET: offset_q <= cfg_data_i[wrms_pkg::OFFSET_W-1:0];
        wrms_pkg::REG_SENSITIVITY: sens_q   <= cfg_data_i[wrms_pkg::SENS_W-1:0];
        wrms_pkg::REG_WINDOW_LEN:  len_q    <= cfg_data_i[wrms_pkg::LEN_W-1:0];
        wrms_pkg::REG_LOW_CUTOFF:  low_q    <= cfg_data_i[wrms_pkg::CUT_W-1:0];
        wrms_pkg::REG_HIGH_CUTOFF: high_q   <= cfg_data_i[wrms_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.zero_offset = offset_q;
    cfg_o.low_cut     = low_q;
    cfg_o.high_cut    = high_q;
    cfg_o.sens_eff    = (sens_q == '0) ? wrms_pkg::SENS_W'(1) : sens_q;
    priority if (len_q == '0) begin
      cfg_o.len_eff = wrms_pkg::LEN_W'(1);
    end else if (int'(len_q) > wrms_pkg::MAX_WINDOW) begin
      cfg_o.len_eff = wrms_pkg::LEN_W'(wrms_pkg::MAX_WINDOW);
    end else begin
      cfg_o.len_eff = len_q;
    end
  end

endmodule

FILE: src/wrms_ctrl.sv
// ----------------------------------------------------------------------------
// wrms_ctrl
// Sequencer: takes a sample, squares and accumulates it, and at window end
// steps the datapath through mean division, square root, scaling,
// conversion division and result load.
// ----------------------------------------------------------------------------
module wrms_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wrms_pkg::dp_stat_t   stat_i,
  output wrms_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MEAN_LOAD,
    ST_MEAN_DIV,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_SCALE,
    ST_CONV_LOAD,
    ST_CONV_DIV,
    ST_EMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [wrms_pkg::ITER_W-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_sample = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accumulate = 1'b1;
        state_d          = stat_i.win_end ? ST_MEAN_LOAD : ST_IDLE;
      end
      ST_MEAN_LOAD: begin
        cmd_o.mean_load = 1'b1;
        iter_d          = wrms_pkg::ITER_W'(wrms_pkg::DVD_W - 1);
        state_d         = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        cmd_o.div_step = 1'b1;
        iter_d         = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_ROOT_LOAD;
        end
      end
      ST_ROOT_LOAD: begin
        cmd_o.root_load = 1'b1;
        iter_d          = wrms_pkg::ITER_W'(wrms_pkg::ROOT_W - 1);
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        iter_d          = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_CONV_LOAD;
      end
      ST_CONV_LOAD: begin
        cmd_o.conv_load = 1'b1;
        iter_d          = wrms_pkg::ITER_W'(wrms_pkg::DVD_W - 1);
        state_d         = ST_CONV_DIV;
      end
      ST_CONV_DIV: begin
        cmd_o.div_step = 1'b1;
        iter_d         = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: src/wrms_dp.sv
// ----------------------------------------------------------------------------
// wrms_dp
// Datapath: offset subtract, square, accumulator and sample counter, shared
// restoring divider, digit-by-digit square root, scale multiplier, range
// check and output register.
// ----------------------------------------------------------------------------
module wrms_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wrms_pkg::cfg_t                       cfg_i,
  input  wrms_pkg::dp_cmd_t                    cmd_i,
  output wrms_pkg::dp_stat_t                   stat_o,
  input  logic [wrms_pkg::SAMPLE_BITS-1:0]     sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [wrms_pkg::CENTI_W-1:0]         centi_o,
  output logic [wrms_pkg::STATUS_W-1:0]        status_o
);

  logic signed [wrms_pkg::DIFF_W-1:0] diff_q;
  logic [wrms_pkg::MAG_W-1:0]         mag;
  logic [wrms_pkg::SQ_W-1:0]          sq_q;
  logic [wrms_pkg::SUM_W-1:0]         sum_q;
  logic [wrms_pkg::CNT_W-1:0]         cnt_q;
  logic [wrms_pkg::CMP_W-1:0]         cnt_inc;

  logic [wrms_pkg::DVD_W-1:0]         dvd_q;
  logic [wrms_pkg::DVS_W-1:0]         dvs_q;
  logic [wrms_pkg::DVS_W-1:0]         rem_q;
  logic [wrms_pkg::DVS_W:0]           rem_sh;
  logic                               rem_ge;

  logic [wrms_pkg::RAD_W-1:0]         rad_q;
  logic [wrms_pkg::ROOT_W-1:0]        root_q;
  logic [wrms_pkg::ROOT_W:0]          srem_q;
  logic [wrms_pkg::ROOT_W+2:0]        srem_sh;
  logic [wrms_pkg::ROOT_W+2:0]        trial;
  logic                               srem_ge;

  logic [wrms_pkg::PROD_W-1:0]        prod_q;

  logic                               out_valid_q;
  logic [wrms_pkg::CENTI_W-1:0]       centi_q;
  logic [wrms_pkg::STATUS_W-1:0]      status_q;
  logic                               below, above;

  assign mag     = diff_q[wrms_pkg::DIFF_W-1] ? wrms_pkg::MAG_W'(-diff_q)
                                              : wrms_pkg::MAG_W'(diff_q);
  assign cnt_inc = wrms_pkg::CMP_W'(cnt_q) + wrms_pkg::CMP_W'(1);

  assign rem_sh  = {rem_q, dvd_q[wrms_pkg::DVD_W-1]};
  assign rem_ge  = (rem_sh >= (wrms_pkg::DVS_W+1)'(dvs_q));

  assign srem_sh = {srem_q, rad_q[wrms_pkg::RAD_W-1 -: 2]};
  assign trial   = (wrms_pkg::ROOT_W+3)'({root_q, 2'b01});
  assign srem_ge = (srem_sh >= trial);

  assign below = (dvd_q < wrms_pkg::DVD_W'(cfg_i.low_cut));
  assign above = (dvd_q > wrms_pkg::DVD_W'(cfg_i.high_cut));

  assign stat_o.win_end  = (cnt_inc >= wrms_pkg::CMP_W'(cfg_i.len_eff));
  assign stat_o.out_busy = out_valid_q;

  // Window state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accumulate) begin
        sum_q <= sum_q + wrms_pkg::SUM_W'(sq_q);
        cnt_q <= wrms_pkg::CNT_W'(cnt_inc);
      end else if (cmd_i.mean_load) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_sample) begin
      diff_q <= $signed(wrms_pkg::DIFF_W'(sample_i)) - $signed(wrms_pkg::DIFF_W'(cfg_i.zero_offset));
    end
    if (cmd_i.square) begin
      sq_q <= wrms_pkg::SQ_W'(mag) * wrms_pkg::SQ_W'(mag);
    end

    if (cmd_i.mean_load) begin
      dvd_q <= wrms_pkg::DVD_W'(sum_q);
      dvs_q <= wrms_pkg::DVS_W'(cfg_i.len_eff);
      rem_q <= '0;
    end else if (cmd_i.conv_load) begin
      dvd_q <= wrms_pkg::DVD_W'(prod_q);
      dvs_q <= wrms_pkg::DVS_W'(cfg_i.sens_eff);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[wrms_pkg::DVD_W-2:0], rem_ge};
      rem_q <= rem_ge ? wrms_pkg::DVS_W'(rem_sh - (wrms_pkg::DVS_W+1)'(dvs_q))
                      : wrms_pkg::DVS_W'(rem_sh);
    end

    if (cmd_i.root_load) begin
      rad_q  <= wrms_pkg::RAD_W'(dvd_q);
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[wrms_pkg::RAD_W-3:0], 2'b00};
      root_q <= {root_q[wrms_pkg::ROOT_W-2:0], srem_ge};
      srem_q <= srem_ge ? (wrms_pkg::ROOT_W+1)'(srem_sh - trial)
                        : (wrms_pkg::ROOT_W+1)'(srem_sh);
    end

    if (cmd_i.scale) begin
      prod_q <= wrms_pkg::PROD_W'(root_q) * wrms_pkg::PROD_W'(wrms_pkg::CENTI_PER_UNIT);
    end

    if (cmd_i.out_load) begin
      priority if (below) begin
        centi_q  <= '0;
        status_q <= wrms_pkg::RANGE_LOW;
      end else if (above) begin
        centi_q  <= '0;
        status_q <= wrms_pkg::RANGE_HIGH;
      end else begin
        centi_q  <= wrms_pkg::CENTI_W'(dvd_q);
        status_q <= wrms_pkg::RANGE_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign centi_o     = centi_q;
  assign status_o    = status_q;

endmodule

FILE: src/windowed_rms_current_meter_core.sv
// ----------------------------------------------------------------------------
// windowed_rms_current_meter_core
// True-RMS current meter: sum of squared offset-corrected samples per window,
// floored mean, integer square root, scaling to centiamps and range check.
//
// Input stream: one sample per item, s_axis_tdata[11:0] in millivolts.
// Output stream: one item per window; tdata holds centiamps, tuser the range
// status (in range, below low cutoff, above high cutoff; forced-zero value
// when out of range).
// Configuration: cfg_valid_i/cfg_ready_o write channel with register index
// and data, always ready; the user must write it only while the block is
// idle, which the block does not enforce. A sample that does not close a
// window passes through the take, square and accumulate states; no new
// sample is accepted until it is done. The closing sample also runs the
// 1-bit-per-cycle restoring divider twice (34 steps each) and the 17-step
// square root unit. While a result waits for m_axis_tready, samples keep
// being accumulated; the next window end holds in its final step until the
// output register frees. Reset restores default registers and clears the
// accumulator, the sample count and any pending result.
// ----------------------------------------------------------------------------
module windowed_rms_current_meter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: [11:0] sample_mv
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wrms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tdata: [15:0] rms_centiamps
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wrms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: [1:0] range_status
  output logic [wrms_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wrms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wrms_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  wrms_pkg::cfg_t                 cfg;
  wrms_pkg::dp_cmd_t              cmd;
  wrms_pkg::dp_stat_t             stat;
  logic [wrms_pkg::CENTI_W-1:0]   centi;

  wrms_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wrms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wrms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .sample_i    (s_axis_tdata[wrms_pkg::SAMPLE_BITS-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .centi_o     (centi),
    .status_o    (m_axis_tuser)
  );

  assign m_axis_tdata = wrms_pkg::OUT_TDATA_W'(centi);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sample taken while previous sample still in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != wrms_pkg::RANGE_OK)) |-> (m_axis_tdata == '0))
    else $error("out-of-range result not forced to zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg.len_eff != '0) && (int'(cfg.len_eff) <= wrms_pkg::MAX_WINDOW) && (cfg.sens_eff != '0))
    else $error("window length or sensitivity clamp failed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !m_axis_tvalid)
    else $error("result loaded over a pending item");

endmodule
